>>> rtl/core/swmq_pkg.sv
// ----------------------------------------------------------------------------
// swmq_pkg: shared types and constants
// Register indexes, reset values and field widths of the window mean quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package swmq_pkg;

	// field widths
	localparam int TEMP_W  = 15;
	localparam int HUM_W   = 14;
	localparam int GAIN_W  = 24;
	localparam int CODE_W  = 8;
	localparam int PIDX_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// default structure
	localparam int DEF_RING_DEPTH = 90;
	localparam int DEF_SEQ_POINTS = 6;
	localparam int DEF_WINDOW_LEN = 15;
	localparam int DEF_TAKE_LEN   = 3;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_OFFSET = 2'd0,
		REG_TEMP_GAIN   = 2'd1,
		REG_HUM_OFFSET  = 2'd2,
		REG_HUM_GAIN    = 2'd3
	} cfg_reg_t;

	localparam logic signed [TEMP_W-1:0] RST_TEMP_OFFSET = 15'sd535;
	localparam logic [GAIN_W-1:0]        RST_TEMP_GAIN   = 24'd689401;
	localparam logic [HUM_W-1:0]         RST_HUM_OFFSET  = 14'd2000;
	localparam logic [GAIN_W-1:0]        RST_HUM_GAIN    = 24'd642959;

	// quotient bits: a mean never exceeds one sample in magnitude
	localparam int QUOT_W = TEMP_W;

	// clamp limits
	localparam logic signed [CODE_W-1:0] CODE_MAX = 8'sd127;
	localparam logic signed [CODE_W-1:0] CODE_MIN = -8'sd128;

endpackage

`default_nettype wire

>>> rtl/core/swmq_ram.sv
// ----------------------------------------------------------------------------
// swmq_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/sensor_window_mean_quantizer_unit.sv
// ----------------------------------------------------------------------------
// sensor_window_mean_quantizer_unit: ring of samples to quantized mean points
// Stores each sample and emits SEQ_POINTS int8 temperature/humidity points.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a ring RAM; the unit then emits
// SEQ_POINTS transactions. Until the ring is full every point carries the mean
// of all stored samples; once full, point i is the mean of the first TAKE_LEN
// samples of window i, oldest first. One RAM read port, one iterative divider
// (QUOT_W steps, both channels side by side) and one multiply/clamp stage are
// shared under the sequencer, so in_ready is low while an item is worked on.
// How long an item takes is set by the ring reads, the divider steps and any
// output stalls. Configuration writes are taken only while the unit is idle.
`default_nettype none

module sensor_window_mean_quantizer_unit
	import swmq_pkg::*;
#(
	parameter int RING_DEPTH = DEF_RING_DEPTH,
	parameter int SEQ_POINTS = DEF_SEQ_POINTS,
	parameter int WINDOW_LEN = DEF_WINDOW_LEN,
	parameter int TAKE_LEN   = DEF_TAKE_LEN
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [TEMP_W-1:0] temp_sample,
	input  wire logic [HUM_W-1:0]         hum_sample,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [PIDX_W-1:0]             point_index,
	output logic signed [CODE_W-1:0]      temp_code,
	output logic signed [CODE_W-1:0]      hum_code,
	output logic                          ring_full,
	output logic                          last_point,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int ADDR_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = TEMP_W + CNT_W;
	localparam int PT_W   = (SEQ_POINTS > 1) ? $clog2(SEQ_POINTS) : 1;
	localparam int STEP_W = $clog2(QUOT_W + 1);
	localparam int AVAIL  = RING_DEPTH / WINDOW_LEN;
	localparam int DIFF_W = QUOT_W + 2;
	localparam int PROD_W = DIFF_W + GAIN_W + 1;
	localparam int SHR_W  = PROD_W - GAIN_W;
	localparam int ROW_W  = TEMP_W + HUM_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SETUP, ST_SUM, ST_DIV, ST_MUL, ST_CLAMP, ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [TEMP_W-1:0] temp_offset_q;
	logic [GAIN_W-1:0]        temp_gain_q;
	logic [HUM_W-1:0]         hum_offset_q;
	logic [GAIN_W-1:0]        hum_gain_q;

	// ring control
	logic [ADDR_W-1:0] wslot_q;
	logic [CNT_W-1:0]  fill_q;
	logic              full_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [CNT_W-1:0]  rd_left_q;
	logic              rd_vld_s1;
	logic [CNT_W-1:0]  den_q;
	logic [PT_W-1:0]   pt_q;

	// accumulators and divider
	logic signed [SUM_W-1:0] tsum_q, hsum_q;
	logic [SUM_W-1:0]        trem_q, hrem_q, dsh_q;
	logic [QUOT_W-1:0]       tquo_q, hquo_q;
	logic                    tneg_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [PROD_W-1:0] tprod_q, hprod_q;

	logic [ROW_W-1:0] rd_row;

	// ring RAM: temperature and humidity side by side
	swmq_ram #(
		.WIDTH (ROW_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (in_valid && in_ready),
		.waddr (wslot_q),
		.wdata ({temp_sample, hum_sample}),
		.raddr (rd_addr_q),
		.rdata (rd_row)
	);

	// hold configuration while an item is in flight
	assign cfg_ready = (state_q == ST_IDLE);

	// config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_offset_q <= RST_TEMP_OFFSET;
			temp_gain_q   <= RST_TEMP_GAIN;
			hum_offset_q  <= RST_HUM_OFFSET;
			hum_gain_q    <= RST_HUM_GAIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEMP_OFFSET: temp_offset_q <= cfg_data[TEMP_W-1:0];
				REG_TEMP_GAIN:   temp_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_HUM_OFFSET:  hum_offset_q  <= cfg_data[HUM_W-1:0];
				REG_HUM_GAIN:    hum_gain_q    <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// window placement for the current point once the ring is full
	logic [ADDR_W-1:0] win_addr;
	logic [CNT_W-1:0]  win_cnt;
	always_comb begin
		int st;
		int cn;
		logic [ADDR_W:0] asum;
		st = (AVAIL - SEQ_POINTS + int'(pt_q)) * WINDOW_LEN;
		if (st < 0) st = 0;
		cn = RING_DEPTH - st;
		if (cn > WINDOW_LEN) cn = WINDOW_LEN;
		if (cn > TAKE_LEN) cn = TAKE_LEN;
		asum = {1'b0, wslot_q} + (ADDR_W+1)'(st);
		if (asum >= (ADDR_W+1)'(RING_DEPTH)) asum = asum - (ADDR_W+1)'(RING_DEPTH);
		win_addr = asum[ADDR_W-1:0];
		win_cnt  = CNT_W'(cn);
	end

	// divider step for both channels
	logic [SUM_W-1:0] trem_n, hrem_n;
	logic             tbit, hbit;
	always_comb begin
		tbit   = (trem_q >= dsh_q);
		hbit   = (hrem_q >= dsh_q);
		trem_n = tbit ? trem_q - dsh_q : trem_q;
		hrem_n = hbit ? hrem_q - dsh_q : hrem_q;
	end

	// means, offsets removed
	logic signed [DIFF_W-1:0] tdiff, hdiff;
	always_comb begin
		logic signed [DIFF_W-1:0] tmean;
		tmean = tneg_q ? -$signed({2'b00, tquo_q}) : $signed({2'b00, tquo_q});
		tdiff = tmean - DIFF_W'(temp_offset_q);
		hdiff = $signed({2'b00, hquo_q}) - $signed({{(DIFF_W-HUM_W){1'b0}}, hum_offset_q});
	end

	// truncate toward zero and clamp
	function automatic logic signed [CODE_W-1:0] clamp_code(logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [SHR_W-1:0]  sh;
		logic [CODE_W-1:0] c;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		sh  = mag[PROD_W-1:GAIN_W];
		if (p[PROD_W-1]) begin
			if (sh >= SHR_W'(128)) c = CODE_MIN;
			else c = CODE_W'(-$signed({1'b0, sh}));
		end else begin
			if (sh >= SHR_W'(127)) c = CODE_MAX;
			else c = sh[CODE_W-1:0];
		end
		return $signed(c);
	endfunction

	assign in_ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wslot_q     <= '0;
			fill_q      <= '0;
			full_q      <= 1'b0;
			rd_addr_q   <= '0;
			rd_left_q   <= '0;
			rd_vld_s1   <= 1'b0;
			den_q       <= '0;
			pt_q        <= '0;
			tsum_q      <= '0;
			hsum_q      <= '0;
			trem_q      <= '0;
			hrem_q      <= '0;
			dsh_q       <= '0;
			tquo_q      <= '0;
			hquo_q      <= '0;
			tneg_q      <= 1'b0;
			step_q      <= '0;
			tprod_q     <= '0;
			hprod_q     <= '0;
			out_valid   <= 1'b0;
			point_index <= '0;
			temp_code   <= '0;
			hum_code    <= '0;
			ring_full   <= 1'b0;
			last_point  <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						wslot_q <= (wslot_q == ADDR_W'(RING_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
						if (fill_q != CNT_W'(RING_DEPTH)) fill_q <= fill_q + 1'b1;
						full_q  <= (fill_q >= CNT_W'(RING_DEPTH - 1));
						pt_q    <= '0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					// load one read run: all samples, or one window
					tsum_q <= '0;
					hsum_q <= '0;
					if (full_q) begin
						rd_addr_q <= win_addr;
						rd_left_q <= win_cnt;
						den_q     <= win_cnt;
					end else begin
						rd_addr_q <= '0;
						rd_left_q <= fill_q;
						den_q     <= fill_q;
					end
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (rd_left_q != '0) begin
						rd_addr_q <= (rd_addr_q == ADDR_W'(RING_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
						rd_left_q <= rd_left_q - 1'b1;
						rd_vld_s1 <= 1'b1;
					end
					if (rd_vld_s1) begin
						tsum_q <= tsum_q + SUM_W'($signed(rd_row[ROW_W-1:HUM_W]));
						hsum_q <= hsum_q + SUM_W'(rd_row[HUM_W-1:0]);
					end else if (rd_left_q == '0) begin
						// hand the sums to the divider as magnitudes
						tneg_q  <= tsum_q[SUM_W-1];
						trem_q  <= tsum_q[SUM_W-1] ? SUM_W'(-tsum_q) : SUM_W'(tsum_q);
						hrem_q  <= SUM_W'(hsum_q);
						dsh_q   <= SUM_W'(den_q) << (QUOT_W - 1);
						tquo_q  <= '0;
						hquo_q  <= '0;
						step_q  <= STEP_W'(QUOT_W);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					trem_q <= trem_n;
					hrem_q <= hrem_n;
					tquo_q <= {tquo_q[QUOT_W-2:0], tbit};
					hquo_q <= {hquo_q[QUOT_W-2:0], hbit};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) state_q <= ST_MUL;
				end
				ST_MUL: begin
					tprod_q <= PROD_W'(tdiff) * $signed({1'b0, temp_gain_q});
					hprod_q <= PROD_W'(hdiff) * $signed({1'b0, hum_gain_q});
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					temp_code   <= clamp_code(tprod_q);
					hum_code    <= clamp_code(hprod_q);
					point_index <= PIDX_W'(pt_q);
					ring_full   <= full_q;
					last_point  <= (pt_q == PT_W'(SEQ_POINTS - 1));
					out_valid   <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (pt_q == PT_W'(SEQ_POINTS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							pt_q <= pt_q + 1'b1;
							if (full_q) begin
								state_q <= ST_SETUP;
							end else begin
								// same global mean for every point: reissue the codes
								state_q <= ST_CLAMP;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a point is pending");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_point) |-> (pt_q == PT_W'(SEQ_POINTS - 1)))
		else $error("last point flagged at wrong index");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (full_q == (fill_q == CNT_W'(RING_DEPTH))))
		else $error("full flag disagrees with fill count");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_point) |=> in_ready)
		else $error("unit not idle after final point");

endmodule

`default_nettype wire

>>> dv/sensor_window_mean_quantizer_unit_tb.sv
// ----------------------------------------------------------------------------
// sensor_window_mean_quantizer_unit_tb: self-checking bench for the quantizer
// Drives sample transactions in random bursts and stalls the point stream on
// its own pattern. Each point is checked against a ring model that computes
// the mean points, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_window_mean_quantizer_unit_tb;
	import swmq_pkg::*;

	localparam int DEPTH     = DEF_RING_DEPTH;
	localparam int NPOINTS   = DEF_SEQ_POINTS;
	localparam int WIN       = DEF_WINDOW_LEN;
	localparam int TAKE      = DEF_TAKE_LEN;
	localparam int CYCLE_CAP = 600000;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
	} sample_t;

	typedef struct packed {
		logic [PIDX_W-1:0]        pidx;
		logic signed [CODE_W-1:0] tcode;
		logic signed [CODE_W-1:0] hcode;
		logic                     full;
		logic                     last;
	} point_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic signed [TEMP_W-1:0] temp_sample;
	logic [HUM_W-1:0] hum_sample;
	logic [PIDX_W-1:0] point_index;
	logic signed [CODE_W-1:0] temp_code, hum_code;
	logic ring_full, last_point;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sensor_window_mean_quantizer_unit dut (.*);

	// sample ring and register copies of the block
	longint temp_hist [DEPTH];
	longint hum_hist [DEPTH];
	int slot_wr, n_stored;
	longint t_off, t_gain, h_off, h_gain;

	sample_t pending_samples[$];
	point_t expected_points[$];
	int errors;
	int cycles;
	int burst_left, gap_left;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic logic signed [CODE_W-1:0] to_code(longint mean, longint off, longint gain);
		longint p, q;
		p = (mean - off) * gain;
		q = (p < 0) ? -((-p) >>> 24) : (p >>> 24);
		if (q > 127) q = 127;
		if (q < -128) q = -128;
		return q[CODE_W-1:0];
	endfunction

	// mean over stored samples first .. first+count-1, oldest first
	task automatic range_mean(input int first, input int count, output longint tm, output longint hm);
		longint ts, hs;
		int s;
		ts = 0;
		hs = 0;
		for (int k = 0; k < count; k++) begin
			s = (slot_wr + DEPTH - n_stored + first + k) % DEPTH;
			ts += temp_hist[s];
			hs += hum_hist[s];
		end
		if (count == 0) count = 1;
		tm = ts / count;
		hm = hs / count;
	endtask

	// store one sample and queue the points it produces
	task automatic predict_points(input sample_t smp);
		longint gtm, ghm, tm, hm, start, stop, cnt;
		logic full;
		point_t pt;
		temp_hist[slot_wr] = smp.temp;
		hum_hist[slot_wr] = smp.hum;
		slot_wr = (slot_wr + 1) % DEPTH;
		if (n_stored < DEPTH) n_stored++;
		full = (n_stored >= DEPTH);
		range_mean(0, n_stored, gtm, ghm);
		for (int i = 0; i < NPOINTS; i++) begin
			tm = gtm;
			hm = ghm;
			if (full) begin
				start = (n_stored / WIN - NPOINTS + i) * WIN;
				if (start < 0) start = 0;
				stop = start + WIN;
				if (stop > n_stored) stop = n_stored;
				cnt = stop - start;
				if (cnt > TAKE) cnt = TAKE;
				if (cnt > 0) range_mean(int'(start), int'(cnt), tm, hm);
			end
			pt.pidx = i[PIDX_W-1:0];
			pt.tcode = to_code(tm, t_off, t_gain);
			pt.hcode = to_code(hm, h_off, h_gain);
			pt.full = full;
			pt.last = (i == NPOINTS - 1);
			expected_points.push_back(pt);
		end
	endtask

	// driver: bursts of sample transactions with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			temp_sample <= '0;
			hum_sample <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) predict_points({temp_sample, hum_sample});
			if (in_valid && !in_ready) begin
				// hold until taken
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				sample_t s;
				s = pending_samples.pop_front();
				in_valid <= 1'b1;
				temp_sample <= s.temp;
				hum_sample <= s.hum;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 6);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: stall the point stream and check each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report($sformatf("unexpected point idx=%0d", point_index));
				end else begin
					point_t e;
					e = expected_points.pop_front();
					if (point_index !== e.pidx)
						report($sformatf("point_index %0d exp %0d", point_index, e.pidx));
					if (temp_code !== e.tcode)
						report($sformatf("temp_code %0d exp %0d (idx %0d)",
							temp_code, e.tcode, e.pidx));
					if (hum_code !== e.hcode)
						report($sformatf("hum_code %0d exp %0d (idx %0d)",
							hum_code, e.hcode, e.pidx));
					if (ring_full !== e.full)
						report($sformatf("ring_full %0b exp %0b", ring_full, e.full));
					if (last_point !== e.last)
						report($sformatf("last_point %0b exp %0b", last_point, e.last));
				end
			end
			// free-flowing stretches alternate with random and heavy stalls
			case (cycles[12:11])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= ($urandom_range(0, 4) == 0);
				default: out_ready <= cycles[3];
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("sensor_window_mean_quantizer_unit_tb: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TEMP_OFFSET: t_off = longint'($signed(d[TEMP_W-1:0]));
			REG_TEMP_GAIN:   t_gain = d;
			REG_HUM_OFFSET:  h_off = d[HUM_W-1:0];
			REG_HUM_GAIN:    h_gain = d;
		endcase
	endtask

	task automatic set_regs(input int toff, input int tg, input int hoff, input int hg);
		write_reg(REG_TEMP_OFFSET, CFG_DATA_W'(toff));
		write_reg(REG_TEMP_GAIN, CFG_DATA_W'(tg));
		write_reg(REG_HUM_OFFSET, CFG_DATA_W'(hoff));
		write_reg(REG_HUM_GAIN, CFG_DATA_W'(hg));
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_samples.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic sample_t rand_sample();
		sample_t s;
		if ($urandom_range(0, 9) == 0) begin
			s.temp = TEMP_W'($urandom);
			s.hum = HUM_W'($urandom);
		end else begin
			s.temp = TEMP_W'($signed($urandom_range(0, 16500)) - 4000);
			s.hum = HUM_W'($urandom_range(0, 10000));
		end
		return s;
	endfunction

	task automatic add_random(input int n);
		for (int i = 0; i < n; i++) pending_samples.push_back(rand_sample());
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		slot_wr = 0;
		n_stored = 0;
		t_off = RST_TEMP_OFFSET;
		t_gain = RST_TEMP_GAIN;
		h_off = RST_HUM_OFFSET;
		h_gain = RST_HUM_GAIN;
		cfg_valid = 1'b0;
		cfg_index = REG_TEMP_OFFSET;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset values first, then directed extremes including out-of-range fields
		repeat (2) @(posedge clk);
		pending_samples.push_back('{15'sd0, 14'd0});
		pending_samples.push_back('{-15'sd4000, 14'd10000});
		pending_samples.push_back('{15'sd12500, 14'd0});
		pending_samples.push_back('{-15'sd16384, 14'd16383});
		pending_samples.push_back('{15'sd16383, 14'd16383});
		pending_samples.push_back('{15'sd535, 14'd2000});
		wait_idle();
		set_regs(-4000, 24'hFFFFFF, 10000, 24'hFFFFFF);
		pending_samples.push_back('{15'sd12500, 14'd0});
		pending_samples.push_back('{-15'sd4000, 14'd10000});
		pending_samples.push_back('{-15'sd3999, 14'd9999});
		pending_samples.push_back('{15'sd16383, 14'd16383});
		pending_samples.push_back('{-15'sd16384, 14'd0});
		pending_samples.push_back('{15'sd0, 14'h2AAA});
		pending_samples.push_back('{15'sh2AAA, 14'h1555});
		pending_samples.push_back('{15'sh5555, 14'h2AAA});
		wait_idle();
		set_regs(12500, 0, 0, 0);
		pending_samples.push_back('{15'sd12500, 14'd10000});
		pending_samples.push_back('{-15'sd4000, 14'd0});
		wait_idle();

		// random phases; the ring fills partway through the second
		set_regs(24'hFFC000, 24'h800000, 24'h003FFF, 24'h000001);
		add_random(40);
		wait_idle();
		set_regs(535, 689401, 2000, 642959);
		add_random(50);
		wait_idle();
		set_regs($urandom_range(0, 16500) - 4000, $urandom, $urandom_range(0, 10000),
			$urandom_range(0, 4000000));
		add_random(40);
		wait_idle();

		if (errors == 0)
			$display("sensor_window_mean_quantizer_unit_tb: PASS");
		else
			$display("sensor_window_mean_quantizer_unit_tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/swmq_pkg.sv
rtl/core/swmq_ram.sv
rtl/core/sensor_window_mean_quantizer_unit.sv
dv/sensor_window_mean_quantizer_unit_tb.sv
